// ----- rtl/nps_pkg.sv -----
// Shared types and constants for the note pattern sequencer.
// No dependencies.
`timescale 1ns / 1ps
package nps_pkg;
	localparam int MAX_STEPS    = 256;
	localparam int NUM_CHANNELS = 5;
	localparam int STEP_W       = $clog2(MAX_STEPS);
	localparam int LOOP_W       = 9;
	localparam int CH_W         = 3;
	localparam int ADDR_W       = CH_W + STEP_W;
	localparam int NOTE_W       = 51;
	localparam int DIV_BITS     = 32;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SEEK  = 2'd2;

	localparam logic [1:0] REG_LOOP   = 2'd0;
	localparam logic [1:0] REG_SPS    = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	localparam logic [2:0] FLAG_PLAY     = 3'h1;
	localparam logic [2:0] FLAG_STACCATO = 3'h2;
	localparam logic [2:0] FLAG_DOUBLE   = 3'h4;

	typedef struct packed {
		logic [2:0]  flags;
		logic [15:0] f0;
		logic [15:0] f1;
		logic [7:0]  v0;
		logic [7:0]  v1;
	} note_t;

	// controller -> datapath
	typedef struct packed {
		logic mem_write;    // store the input note
		logic mem_read;     // read note of rd_ch at current step
		logic [CH_W-1:0] rd_ch;
		logic seek;         // apply seek
		logic normalize;    // fold out-of-range position
		logic div_start;    // start the interpolation divisions
		logic load_out;     // capture result into output register
		logic last;         // result is last of tick
		logic advance;      // advance position by one sample
	} nps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
	} nps_sts_t;
endpackage

// ----- rtl/nps_ctrl.sv -----
// Controller state machine: sequences writes, seeks and the per-channel tick work.
// Depends on nps_pkg.
`timescale 1ns / 1ps
module nps_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   in_opcode,
	input  logic [4:0]                   enable,
	input  logic                         out_busy,
	input  nps_pkg::nps_sts_t            sts,
	output nps_pkg::nps_cmd_t            cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_READ, ST_START, ST_DIV, ST_EMIT, ST_ADV
	} state_t;

	state_t                       state_q;
	logic [nps_pkg::CH_W-1:0]     ch_q;
	logic                         accept;
	logic [nps_pkg::NUM_CHANNELS-1:0] en_v;
	logic                         more;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		en_v = enable[nps_pkg::NUM_CHANNELS-1:0];
		// any enabled channel above ch_q
		more = 1'b0;
		for (int i = 0; i < nps_pkg::NUM_CHANNELS; i++) begin
			if (en_v[i] && (i > int'(ch_q))) more = 1'b1;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.rd_ch = ch_q;
		case (state_q)
			ST_IDLE: begin
				cmd.mem_write = accept && (in_opcode == nps_pkg::OP_WRITE);
				cmd.seek      = accept && (in_opcode == nps_pkg::OP_SEEK);
				cmd.normalize = accept && (in_opcode == nps_pkg::OP_TICK);
			end
			ST_READ:  cmd.mem_read = 1'b1;
			ST_START: cmd.div_start = 1'b1;
			ST_EMIT: begin
				cmd.load_out = !out_busy;
				cmd.last     = !more;
			end
			ST_ADV:   cmd.advance = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && in_opcode == nps_pkg::OP_TICK) begin
						state_q <= ST_SCAN;
						ch_q    <= '0;
					end
				end
				ST_SCAN: begin
					if (en_v[ch_q]) state_q <= ST_READ;
					else if (more) ch_q <= ch_q + 1'b1;
					else state_q <= ST_ADV;
				end
				ST_READ:  state_q <= ST_START;
				ST_START: state_q <= ST_DIV;
				ST_DIV:   if (sts.div_done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!out_busy) begin
						if (more) begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_ADV;
						end
					end
				end
				ST_ADV:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/nps_div.sv -----
// Restoring divider, one quotient bit per cycle, dividing two values at once.
// Depends on nps_pkg.
`timescale 1ns / 1ps
module nps_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num_a,
	input  logic [31:0] num_b,
	input  logic [15:0] den,
	output logic [31:0] quo_a,
	output logic [31:0] quo_b,
	output logic        done
);
	localparam int CNT_W = $clog2(nps_pkg::DIV_BITS + 1);
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [31:0]      qa_q, qb_q;
	logic [16:0]      ra_q, rb_q;
	logic [16:0]      ta, tb;

	always_comb begin
		ta = {ra_q[15:0], qa_q[31]};
		tb = {rb_q[15:0], qb_q[31]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(nps_pkg::DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qa_q <= num_a;
			qb_q <= num_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (busy_q) begin
			if (ta >= {1'b0, den}) begin
				ra_q <= ta - {1'b0, den};
				qa_q <= {qa_q[30:0], 1'b1};
			end else begin
				ra_q <= ta;
				qa_q <= {qa_q[30:0], 1'b0};
			end
			if (tb >= {1'b0, den}) begin
				rb_q <= tb - {1'b0, den};
				qb_q <= {qb_q[30:0], 1'b1};
			end else begin
				rb_q <= tb;
				qb_q <= {qb_q[30:0], 1'b0};
			end
		end
	end

	assign quo_a = qa_q;
	assign quo_b = qb_q;
endmodule

// ----- rtl/nps_datapath.sv -----
// Datapath: pattern memory, position counters, gating, interpolation, output register.
// Depends on nps_pkg and nps_div.
`timescale 1ns / 1ps
module nps_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  nps_pkg::nps_cmd_t cmd,
	output nps_pkg::nps_sts_t sts,
	input  logic [nps_pkg::LOOP_W-1:0] loop_len,
	input  logic [15:0]       sps,
	input  logic [2:0]        channel,
	input  logic [7:0]        step_index,
	input  logic [2:0]        note_flags,
	input  logic [15:0]       freq_start,
	input  logic [15:0]       freq_end,
	input  logic [7:0]        vol_start,
	input  logic [7:0]        vol_end,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [2:0]        out_channel,
	output logic [15:0]       frequency,
	output logic [7:0]        amplitude,
	output logic              last_of_tick
);
	localparam int DEPTH = nps_pkg::NUM_CHANNELS * nps_pkg::MAX_STEPS;
	localparam int SW = nps_pkg::STEP_W;

	// memory cleared by a sweep after reset; the top level stalls input for
	// the same number of cycles, so no write overlaps the sweep
	nps_pkg::note_t               mem [DEPTH];
	nps_pkg::note_t               rd_q;
	logic [nps_pkg::ADDR_W-1:0]   clr_q;
	logic                         clr_busy_q;

	logic [nps_pkg::LOOP_W-1:0]   eff_loop;
	logic [15:0]                  len;
	logic [SW-1:0]                step_q;
	logic [15:0]                  pos_q;
	logic [2:0]                   ch_q;

	always_comb begin
		if (loop_len == '0) eff_loop = nps_pkg::LOOP_W'(1);
		else if (loop_len > nps_pkg::LOOP_W'(nps_pkg::MAX_STEPS))
			eff_loop = nps_pkg::LOOP_W'(nps_pkg::MAX_STEPS);
		else eff_loop = loop_len;
		len = (sps == 16'd0) ? 16'd1 : sps;
	end

	logic [nps_pkg::ADDR_W-1:0] wr_addr, rd_addr;
	logic                       wr_ok;
	assign wr_addr = nps_pkg::ADDR_W'(channel * nps_pkg::MAX_STEPS)
		+ nps_pkg::ADDR_W'(step_index);
	assign rd_addr = nps_pkg::ADDR_W'(cmd.rd_ch * nps_pkg::MAX_STEPS)
		+ nps_pkg::ADDR_W'(step_q);
	assign wr_ok = cmd.mem_write && ({1'b0, step_index} < eff_loop)
		&& (channel < 3'(nps_pkg::NUM_CHANNELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == nps_pkg::ADDR_W'(DEPTH - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) mem[clr_q] <= '0;
		else if (wr_ok) mem[wr_addr] <= {note_flags, freq_start, freq_end, vol_start, vol_end};
		if (cmd.mem_read) rd_q <= mem[rd_addr];
	end

	// position
	logic [15:0] pos_n;
	assign pos_n = pos_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			pos_q  <= '0;
		end else begin
			if (cmd.seek && ({1'b0, step_index} < eff_loop)) begin
				step_q <= SW'(step_index);
				pos_q  <= '0;
			end
			if (cmd.normalize) begin
				if (pos_q >= len) pos_q <= '0;
				if ({1'b0, step_q} >= eff_loop) step_q <= '0;
			end
			if (cmd.advance) begin
				if (pos_n >= len) begin
					pos_q <= '0;
					if ({1'b0, step_q} + 1'b1 >= eff_loop) step_q <= '0;
					else step_q <= step_q + 1'b1;
				end else begin
					pos_q <= pos_n;
				end
			end
		end
	end

	// gate and interpolation setup
	logic [12:0] q8;
	logic [15:0] q3, q4;
	logic [15:0] q7;
	logic        gate_s1;
	logic        f_up_s1, v_up_s1;
	logic [15:0] f_base_s1;
	logic [7:0]  v_base_s1;
	logic [31:0] num_f, num_v;
	logic [15:0] df;
	logic [7:0]  dv;

	always_comb begin
		q8 = len[15:3];
		q3 = 16'({3'b0, q8} * 16'd3);
		q4 = {q8, 3'b0} >> 1;
		q7 = 16'({3'b0, q8} * 16'd7);
		df = (rd_q.f1 >= rd_q.f0) ? rd_q.f1 - rd_q.f0 : rd_q.f0 - rd_q.f1;
		dv = (rd_q.v1 >= rd_q.v0) ? rd_q.v1 - rd_q.v0 : rd_q.v0 - rd_q.v1;
		num_f = 32'(df) * 32'(pos_q);
		num_v = 32'(dv) * 32'(pos_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			gate_s1 <= !(|(rd_q.flags & nps_pkg::FLAG_PLAY))
				|| ((|(rd_q.flags & nps_pkg::FLAG_STACCATO)) && pos_q >= q7)
				|| ((|(rd_q.flags & nps_pkg::FLAG_DOUBLE)) && pos_q >= q3 && pos_q < q4);
			f_up_s1   <= rd_q.f1 >= rd_q.f0;
			v_up_s1   <= rd_q.v1 >= rd_q.v0;
			f_base_s1 <= rd_q.f0;
			v_base_s1 <= rd_q.v0;
			ch_q      <= cmd.rd_ch;
		end
	end

	logic [31:0] quo_f, quo_v;
	logic        done;
	nps_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num_a(num_f), .num_b(num_v), .den(len),
		.quo_a(quo_f), .quo_b(quo_v), .done(done)
	);
	assign sts.div_done = done;

	logic [15:0] f_res;
	logic [7:0]  v_res;
	always_comb begin
		f_res = f_up_s1 ? f_base_s1 + quo_f[15:0] : f_base_s1 - quo_f[15:0];
		v_res = v_up_s1 ? v_base_s1 + quo_v[7:0] : v_base_s1 - quo_v[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.load_out) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_channel  <= ch_q;
			frequency    <= gate_s1 ? 16'd0 : f_res;
			amplitude    <= gate_s1 ? 8'd0 : v_res;
			last_of_tick <= cmd.last;
		end
	end
endmodule

// ----- rtl/note_pattern_sequencer_top.sv -----
// Note pattern sequencer: one transfer in at a time; a tick yields one result
// per enabled channel, each after a divide by the bit-serial divider; write
// and seek are done without the controller leaving its idle state.
// Throughput limited by the shared bit-serial divider.
// After reset the input stalls while the pattern memory clears.
// Depends on nps_pkg, nps_ctrl, nps_datapath.
`timescale 1ns / 1ps
module note_pattern_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  channel,
	input  logic [7:0]  step_index,
	input  logic [2:0]  note_flags,
	input  logic [15:0] freq_start,
	input  logic [15:0] freq_end,
	input  logic [7:0]  vol_start,
	input  logic [7:0]  vol_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  out_channel,
	output logic [15:0] frequency,
	output logic [7:0]  amplitude,
	output logic        last_of_tick
);
	logic [nps_pkg::LOOP_W-1:0] loop_q;
	logic [15:0]                sps_q;
	logic [4:0]                 en_q;
	logic [10:0]                clr_cnt_q;
	logic                       ctrl_stall;
	nps_pkg::nps_cmd_t          cmd;
	nps_pkg::nps_sts_t          sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_q <= 9'd16;
			sps_q  <= 16'd5512;
			en_q   <= 5'd31;
		end else if (cfg_we) begin
			case (cfg_index)
				nps_pkg::REG_LOOP:   loop_q <= cfg_data[8:0];
				nps_pkg::REG_SPS:    sps_q  <= cfg_data;
				nps_pkg::REG_ENABLE: en_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// hold off input while datapath clears memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (clr_cnt_q != 11'(nps_pkg::NUM_CHANNELS * nps_pkg::MAX_STEPS))
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	logic clearing;
	assign clearing = (clr_cnt_q != 11'(nps_pkg::NUM_CHANNELS * nps_pkg::MAX_STEPS));
	assign in_stall = ctrl_stall || clearing;

	nps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid && !clearing), .in_stall(ctrl_stall),
		.in_opcode(opcode), .enable(en_q), .out_busy(out_valid && out_stall),
		.sts(sts), .cmd(cmd)
	);

	nps_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.loop_len(loop_q), .sps(sps_q),
		.channel(channel), .step_index(step_index), .note_flags(note_flags),
		.freq_start(freq_start), .freq_end(freq_end),
		.vol_start(vol_start), .vol_end(vol_end),
		.out_stall(out_stall), .out_valid(out_valid),
		.out_channel(out_channel), .frequency(frequency),
		.amplitude(amplitude), .last_of_tick(last_of_tick)
	);
endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for note_pattern_sequencer_top: directed table, then random phases
// checked against an in-bench predictor of pattern store, position and gating.
// Depends on nps_pkg and the sequencer RTL.
`timescale 1ns / 1ps
module testbench;
	typedef struct {
		logic [2:0]  ch;
		logic [15:0] freq;
		logic [7:0]  amp;
		logic        last;
	} chan_out_t;

	typedef struct {
		logic [1:0]  op;
		logic [2:0]  ch;
		logic [7:0]  idx;
		logic [2:0]  flags;
		logic [15:0] f0;
		logic [15:0] f1;
		logic [7:0]  v0;
		logic [7:0]  v1;
		bit          silent;   // results known to be zero at a glance
	} seq_item_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 250;
	// opcode with no function
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = nps_pkg::REG_LOOP;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = nps_pkg::OP_TICK;
	logic [2:0]  channel = '0;
	logic [7:0]  step_index = '0;
	logic [2:0]  note_flags = '0;
	logic [15:0] freq_start = '0;
	logic [15:0] freq_end = '0;
	logic [7:0]  vol_start = '0;
	logic [7:0]  vol_end = '0;
	logic        item_silent = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  out_channel;
	logic [15:0] frequency;
	logic [7:0]  amplitude;
	logic        last_of_tick;

	note_pattern_sequencer_top DUT (.*);

	always #2 clk = ~clk;

	// predictor state
	nps_pkg::note_t pattern [nps_pkg::NUM_CHANNELS][nps_pkg::MAX_STEPS];
	logic [7:0]  cur_step;
	logic [15:0] cur_sample;
	logic [8:0]  loop_reg;
	logic [15:0] sps_reg;
	logic [4:0]  enable_reg;
	chan_out_t   expected_q[$];
	int          errors = 0;
	int          results_seen = 0;
	int          idle_cycles = 0;

	function automatic logic [31:0] lerp_val(logic [31:0] s, logic [31:0] e,
			logic [31:0] pos, logic [31:0] len);
		logic [63:0] prod;
		if (e >= s) begin
			prod = 64'(e - s) * pos;
			return s + 32'(prod / len);
		end
		prod = 64'(s - e) * pos;
		return s - 32'(prod / len);
	endfunction

	function automatic bit is_gated(logic [2:0] flags, logic [31:0] pos, logic [31:0] len);
		logic [31:0] q;
		q = len / 8;
		if ((flags & nps_pkg::FLAG_PLAY) == 0) return 1;
		if ((flags & nps_pkg::FLAG_STACCATO) != 0 && pos >= q * 7) return 1;
		if ((flags & nps_pkg::FLAG_DOUBLE) != 0 && pos >= q * 3 && pos < q * 4) return 1;
		return 0;
	endfunction

	function automatic void play_item(seq_item_t it);
		logic [31:0]    loop_len;
		logic [31:0]    len;
		chan_out_t      r;
		nps_pkg::note_t n;
		int             count;
		loop_len = (loop_reg == 0) ? 1 : (loop_reg > nps_pkg::MAX_STEPS) ?
			nps_pkg::MAX_STEPS : loop_reg;
		len = (sps_reg == 0) ? 1 : sps_reg;
		count = 0;
		case (it.op)
			nps_pkg::OP_WRITE: begin
				if (it.idx < loop_len && it.ch < nps_pkg::NUM_CHANNELS)
					pattern[it.ch][it.idx] = '{it.flags, it.f0, it.f1, it.v0, it.v1};
			end
			nps_pkg::OP_SEEK: begin
				if (it.idx < loop_len) begin
					cur_step = it.idx;
					cur_sample = '0;
				end
			end
			nps_pkg::OP_TICK: begin
				if (cur_sample >= len) cur_sample = '0;
				if (cur_step >= loop_len) cur_step = '0;
				for (int c = 0; c < nps_pkg::NUM_CHANNELS; c++) begin
					if (enable_reg[c]) begin
						n = pattern[c][cur_step];
						r.ch = 3'(c);
						r.freq = '0;
						r.amp = '0;
						r.last = 1'b0;
						if (!is_gated(n.flags, cur_sample, len) && !it.silent) begin
							r.freq = 16'(lerp_val(n.f0, n.f1, cur_sample, len));
							r.amp = 8'(lerp_val(n.v0, n.v1, cur_sample, len));
						end
						expected_q.push_back(r);
						count++;
					end
				end
				if (count > 0) expected_q[$].last = 1'b1;
				cur_sample = cur_sample + 1;
				if (cur_sample >= len) begin
					cur_sample = '0;
					cur_step = cur_step + 1;
					if (cur_step >= loop_len) cur_step = '0;
				end
			end
			default: ;
		endcase
	endfunction

	// accepted transfers and results, sampled at the rising edge
	always @(posedge clk) begin
		chan_out_t e;
		if (!arst_n) begin
			for (int c = 0; c < nps_pkg::NUM_CHANNELS; c++)
				for (int s = 0; s < nps_pkg::MAX_STEPS; s++)
					pattern[c][s] = '0;
			cur_step = '0;
			cur_sample = '0;
			loop_reg = 9'd16;
			sps_reg = 16'd5512;
			enable_reg = 5'd31;
		end else begin
			idle_cycles = idle_cycles + 1;
			if (cfg_we) begin
				idle_cycles = 0;
				case (cfg_index)
					nps_pkg::REG_LOOP:   loop_reg = cfg_data[8:0];
					nps_pkg::REG_SPS:    sps_reg = cfg_data;
					nps_pkg::REG_ENABLE: enable_reg = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				idle_cycles = 0;
				play_item('{opcode, channel, step_index, note_flags, freq_start, freq_end,
					vol_start, vol_end, item_silent});
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				results_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result ch=%0d f=%0d a=%0d last=%0d", $time,
						out_channel, frequency, amplitude, last_of_tick);
				end else begin
					e = expected_q.pop_front();
					if (out_channel !== e.ch || frequency !== e.freq || amplitude !== e.amp ||
							last_of_tick !== e.last) begin
						errors++;
						$display("%0t: mismatch exp ch=%0d f=%0d a=%0d last=%0d",
							$time, e.ch, e.freq, e.amp, e.last);
						$display("%0t:          act ch=%0d f=%0d a=%0d last=%0d",
							$time, out_channel, frequency, amplitude, last_of_tick);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: stall pattern that changes mode, plus one long hold-off
	initial begin
		int mode;
		int hold;
		bit held;
		mode = 0;
		hold = 0;
		held = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(63) == 0) mode = $urandom_range(2);
			if (!held && results_seen >= 60) begin
				held = 1;
				hold = 600;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(99) < 30);
					default: out_stall <= ($urandom_range(99) < 75);
				endcase
			end
		end
	end

	int burst_left = 0;
	bit no_gaps = 0;

	task automatic send_item(seq_item_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			no_gaps = ($urandom_range(3) == 0);
			if (!no_gaps) begin
				in_valid = 1'b0;
				repeat ($urandom_range(6)) @(negedge clk);
			end
		end
		burst_left--;
		opcode = it.op;
		channel = it.ch;
		step_index = it.idx;
		note_flags = it.flags;
		freq_start = it.f0;
		freq_end = it.f1;
		vol_start = it.v0;
		vol_end = it.v1;
		item_silent = it.silent;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] index, logic [15:0] value);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(logic [8:0] loop_len, logic [15:0] sps, logic [4:0] en);
		wait_idle();
		write_reg(nps_pkg::REG_LOOP, 16'(loop_len));
		write_reg(nps_pkg::REG_SPS, sps);
		write_reg(nps_pkg::REG_ENABLE, 16'(en));
	endtask

	function automatic seq_item_t random_item();
		seq_item_t it;
		int pick;
		int loop_len;
		loop_len = (loop_reg == 0) ? 1 : (loop_reg > nps_pkg::MAX_STEPS) ?
			nps_pkg::MAX_STEPS : loop_reg;
		pick = $urandom_range(99);
		it.op = (pick < 50) ? nps_pkg::OP_TICK : (pick < 80) ? nps_pkg::OP_WRITE :
			(pick < 95) ? nps_pkg::OP_SEEK : OP_UNUSED;
		it.ch = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		it.idx = ($urandom_range(6) == 0) ? 8'($urandom_range(255))
			: 8'($urandom_range(loop_len - 1));
		it.flags = 3'($urandom_range(7));
		it.f0 = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom);
		it.f1 = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom);
		it.v0 = 8'($urandom);
		it.v1 = 8'($urandom);
		it.silent = 0;
		return it;
	endfunction

	seq_item_t directed [] = '{
		'{nps_pkg::OP_TICK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   1},
		'{nps_pkg::OP_WRITE, 3'd0, 8'd0,   3'd7, 16'd0,    16'hFFFF, 8'd255, 8'd0,   0},
		'{nps_pkg::OP_WRITE, 3'd4, 8'd15,  3'd1, 16'hFFFF, 16'd0,    8'd0,   8'd255, 0},
		'{nps_pkg::OP_WRITE, 3'd1, 8'd0,   3'd3, 16'd1000, 16'd2000, 8'd10,  8'd200, 0},
		'{nps_pkg::OP_WRITE, 3'd2, 8'd0,   3'd5, 16'd500,  16'd100,  8'd128, 8'd64,  0},
		'{nps_pkg::OP_WRITE, 3'd3, 8'd0,   3'd0, 16'd777,  16'd777,  8'd99,  8'd99,  0},
		'{nps_pkg::OP_WRITE, 3'd1, 8'd16,  3'd1, 16'd1,    16'd1,    8'd1,   8'd1,   0},
		'{nps_pkg::OP_WRITE, 3'd5, 8'd1,   3'd1, 16'd1,    16'd1,    8'd1,   8'd1,   0},
		'{nps_pkg::OP_WRITE, 3'd7, 8'd255, 3'd7, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 0},
		'{nps_pkg::OP_TICK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{nps_pkg::OP_SEEK,  3'd0, 8'd15,  3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{nps_pkg::OP_TICK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{nps_pkg::OP_SEEK,  3'd0, 8'd200, 3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{OP_UNUSED,         3'd7, 8'd255, 3'd7, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 0},
		'{nps_pkg::OP_TICK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{nps_pkg::OP_SEEK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{nps_pkg::OP_TICK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0},
		'{nps_pkg::OP_TICK,  3'd0, 8'd0,   3'd0, 16'd0,    16'd0,    8'd0,   8'd0,   0}
	};

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		foreach (directed[i]) send_item(directed[i]);

		// short steps so gate windows and wrap are hit; then extremes
		set_regs(9'd2, 16'd8, 5'd31);
		for (int i = 0; i < 40; i++) send_item(random_item());
		set_regs(9'd0, 16'd0, 5'd0);
		for (int i = 0; i < 20; i++) send_item(random_item());
		set_regs(9'd511, 16'hFFFF, 5'd31);
		for (int i = 0; i < 30; i++) send_item(random_item());
		set_regs(9'd256, 16'd3, 5'd21);
		for (int i = 0; i < 30; i++) send_item(random_item());
		for (int p = 0; p < 6; p++) begin
			set_regs(9'($urandom_range(1, 6)), 16'($urandom_range(8, 40)),
				5'($urandom_range(31)));
			for (int i = 0; i < 40; i++) send_item(random_item());
		end

		wait_idle();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
